// ===== rtl/ohp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohp_pkg
// Shared types, codes, defaults and the opcode mask hash of the profiler.
// ----------------------------------------------------------------------------
package ohp_pkg;

   // Default build parameters
   localparam int unsigned HIST_BITS_DEF    = 10;
   localparam int unsigned OPCODE_COUNT_DEF = 32;
   localparam int unsigned COUNT_BITS_DEF   = 32;

   // Widest history the mask hash supports
   localparam int unsigned HIST_MAX = 20;

   // Xor-multiply hash constants
   localparam logic [63:0] HASH_XOR = 64'h98EC4E6C89452821;
   localparam logic [63:0] HASH_MUL = 64'h8A2E03707344A409;
   localparam int unsigned OR_DRAWS = 3;

   // Item kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Request word
   typedef struct packed {
      logic       kind;
      logic [7:0] opcode;
      logic [9:0] query_history;
   } req_type;

   // Response word
   typedef struct packed {
      logic [9:0]  history_now;
      logic [31:0] count_value;
      logic        ignored;
   } rsp_type;

   // History step control
   typedef struct packed {
      logic       en;
      logic [7:0] opcode;
   } hist_step_type;

   // Per-opcode history masks
   typedef struct packed {
      logic [HIST_MAX-1:0] or_mask;
      logic [HIST_MAX-1:0] flip_mask;
   } mask_pair_type;

   // Elaboration-time mask hash: one draw dropped, OR mask ANDed over the
   // next draws, XOR mask taken from the draw after them.
   function automatic mask_pair_type hash_masks(input int unsigned op,
                                                input int unsigned hist_bits);
      logic [63:0]         seed;
      logic [63:0]         draw;
      logic [HIST_MAX-1:0] keep;
      logic [HIST_MAX-1:0] orm;
      logic [HIST_MAX-1:0] xorm;
      mask_pair_type       pair;
      keep = HIST_MAX'((64'd1 << hist_bits) - 64'd1);
      seed = 64'(op);
      orm  = keep;
      xorm = '0;
      for (int i = 0; i < int'(OR_DRAWS) + 2; i++) begin
         seed = (seed ^ HASH_XOR) * HASH_MUL;
         draw = seed >> (64 - hist_bits);
         if (i >= 1 && i <= int'(OR_DRAWS)) begin
            orm = orm & HIST_MAX'(draw);
         end else if (i == int'(OR_DRAWS) + 1) begin
            xorm = HIST_MAX'(draw) & keep;
         end
      end
      pair.or_mask   = orm;
      pair.flip_mask = xorm;
      return pair;
   endfunction

endpackage

// ===== rtl/opcode_history_profiler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opcode_history_profiler
// Saturating counters per (history, opcode) context with a hashed history.
// ----------------------------------------------------------------------------
// Usage:
//   A request word is taken at a rising edge with start high and busy low.
//   kind = record bumps the counter at (current history, opcode) and steps
//   the history; kind = read returns the counter at (query_history, opcode).
//   Opcodes at or above OPCODE_COUNT change nothing and come back flagged.
//   Every request gives exactly one response word, shown on rsp_data for one
//   cycle with rsp_strobe high, after the update stage and the response register.
//   While busy is low a new request may be taken every cycle: the counter RAM
//   is read in the accept cycle and written back in the next cycle, and a read
//   that hits the entry being written in that same cycle is served from a
//   forwarding register, so the RAM's one read and one write port set the rate.
//   The receiver cannot stall; responses are never held.
//   After reset the block clears the counter RAM one entry per cycle, covering
//   all 2^(HIST_BITS + clog2(OPCODE_COUNT)) entries (32768 at the default build);
//   busy stays high for that pass and no request is taken.
// ----------------------------------------------------------------------------
module opcode_history_profiler #(
   parameter int unsigned HIST_BITS    = ohp_pkg::HIST_BITS_DEF,
   parameter int unsigned OPCODE_COUNT = ohp_pkg::OPCODE_COUNT_DEF,
   parameter int unsigned COUNT_BITS   = ohp_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ohp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ohp_pkg::rsp_type rsp_data
);

   localparam int unsigned OP_BITS   = (OPCODE_COUNT > 1) ? $clog2(OPCODE_COUNT) : 1;
   localparam int unsigned ADDR_BITS = HIST_BITS + OP_BITS;

   // Accept side
   logic                   accept;
   logic                   req_ign;
   logic                   req_record;
   logic [HIST_BITS-1:0]   hist_cur;
   logic [HIST_BITS-1:0]   hist_next;
   logic [ADDR_BITS-1:0]   rd_addr;
   ohp_pkg::hist_step_type step;

   // Clearing pass
   logic                 clearing_ff;
   logic                 clearing_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [ADDR_BITS-1:0] clr_addr_in;

   // Update stage
   logic                  s1_valid_ff;
   logic                  s1_record_ff;
   logic                  s1_ign_ff;
   logic [ADDR_BITS-1:0]  s1_addr_ff;
   logic [HIST_BITS-1:0]  s1_hist_ff;
   logic                  fwd_hit_ff;
   logic                  fwd_hit_in;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic [COUNT_BITS-1:0] rsp_count;
   logic                  upd_wr;

   // RAM write port
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // Response register
   logic             rsp_valid_ff;
   ohp_pkg::rsp_type rsp_ff;
   ohp_pkg::rsp_type rsp_in;

   assign busy   = clearing_ff;
   assign accept = start && !busy;

   // Decode the request
   assign req_ign    = {1'b0, req_data.opcode} >= 9'(OPCODE_COUNT);
   assign req_record = req_data.kind == ohp_pkg::KIND_RECORD;

   assign step.en     = accept && req_record && !req_ign;
   assign step.opcode = req_data.opcode;

   ohp_history #(
      .HIST_BITS   (HIST_BITS),
      .OPCODE_COUNT(OPCODE_COUNT)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .hist_cur (hist_cur),
      .hist_next(hist_next)
   );

   // Pick the context to read
   always_comb begin
      if (req_record) begin
         rd_addr = {hist_cur, req_data.opcode[OP_BITS-1:0]};
      end else begin
         rd_addr = {HIST_BITS'(req_data.query_history), req_data.opcode[OP_BITS-1:0]};
      end
   end

   // Advance the clearing pass
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Saturating increment with forwarding from the write in flight
   assign cur_count = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign inc_count = (&cur_count) ? cur_count : cur_count + 1'b1;
   assign upd_wr    = s1_valid_ff && s1_record_ff && !s1_ign_ff;

   assign wr_en   = clearing_ff || upd_wr;
   assign wr_addr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign wr_data = clearing_ff ? '0 : inc_count;

   assign fwd_hit_in = accept && upd_wr && (rd_addr == s1_addr_ff);

   ohp_ram #(
      .WIDTH    (COUNT_BITS),
      .ADDR_BITS(ADDR_BITS)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Form the response word
   always_comb begin
      if (s1_ign_ff) begin
         rsp_count = '0;
      end else if (s1_record_ff) begin
         rsp_count = inc_count;
      end else begin
         rsp_count = cur_count;
      end
      rsp_in.history_now = 10'(s1_hist_ff);
      rsp_in.count_value = 32'(rsp_count);
      rsp_in.ignored     = s1_ign_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= accept;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_record_ff <= req_record;
         s1_ign_ff    <= req_ign;
         s1_addr_ff   <= rd_addr;
         s1_hist_ff   <= hist_next;
      end
      fwd_data_ff <= inc_count;
      if (s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Every taken request is answered by a response strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("response missing two cycles after accept");

   // The update stage never runs during the clearing pass
   a_no_upd_clear: assert property (@(posedge clock) disable iff (reset)
      !(clearing_ff && s1_valid_ff))
      else $error("update stage active while clearing");

   // An ignored word carries a zero count
   a_ign_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.ignored |-> rsp_data.count_value == 32'd0)
      else $error("ignored response with nonzero count");

   // A read leaves the history alone
   a_read_hist: assert property (@(posedge clock) disable iff (reset)
      accept && !req_record |=> $stable(hist_cur))
      else $error("history changed on a read");

endmodule

// ===== rtl/ohp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module ohp_ram #(
   parameter int unsigned WIDTH     = 32,
   parameter int unsigned ADDR_BITS = 15
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   localparam int unsigned DEPTH = 2 ** ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ohp_history.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohp_history
// History register with the per-opcode OR/XOR mask table.
// ----------------------------------------------------------------------------
module ohp_history #(
   parameter int unsigned HIST_BITS    = ohp_pkg::HIST_BITS_DEF,
   parameter int unsigned OPCODE_COUNT = ohp_pkg::OPCODE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ohp_pkg::hist_step_type step,
   output logic [HIST_BITS-1:0]   hist_cur,
   output logic [HIST_BITS-1:0]   hist_next
);

   localparam int unsigned OP_BITS = (OPCODE_COUNT > 1) ? $clog2(OPCODE_COUNT) : 1;

   logic [HIST_BITS-1:0] or_tab  [OPCODE_COUNT];
   logic [HIST_BITS-1:0] xor_tab [OPCODE_COUNT];
   logic [HIST_BITS-1:0] history_ff;
   logic [HIST_BITS-1:0] history_in;
   logic [OP_BITS-1:0]   op_idx;

   // Build the constant mask table
   for (genvar g = 0; g < int'(OPCODE_COUNT); g++) begin : g_mask
      localparam ohp_pkg::mask_pair_type PAIR = ohp_pkg::hash_masks(g, HIST_BITS);
      assign or_tab[g]  = PAIR.or_mask[HIST_BITS-1:0];
      assign xor_tab[g] = PAIR.flip_mask[HIST_BITS-1:0];
   end

   assign op_idx = step.opcode[OP_BITS-1:0];

   // Step the history only for an in-range record
   always_comb begin
      history_in = history_ff;
      if (step.en) begin
         history_in = (history_ff | or_tab[op_idx]) ^ xor_tab[op_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else begin
         history_ff <= history_in;
      end
   end

   assign hist_cur  = history_ff;
   assign hist_next = history_in;

endmodule
